// ----- hw/rtl/xcpp_pkg.sv -----
// Shared types and constants for the XOR-checked command packet parser.
package xcpp_pkg;

  localparam int BYTE_W    = 8;
  localparam int CMD_W     = 16;
  localparam int PLEN_W    = 4;
  localparam int LANE_W    = 3;
  localparam int PAY_LANES = 8;
  localparam int PAY_FIRST = 4;

  localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'hAA;

  typedef logic [BYTE_W-1:0] byte_t;

  // One decoded frame, handed from the front end to the result sequencer.
  typedef struct packed {
    logic [CMD_W-1:0]          cmd_word;
    logic [PLEN_W-1:0]         plen;
    logic                      len_zero;
    logic                      bad;
    logic [LANE_W-1:0]         last_pos;
    byte_t [PAY_LANES-1:0]     payload;
  } xcpp_frame_t;

  typedef struct packed {
    logic full;
    logic empty;
  } xcpp_qstat_t;

endpackage

// ----- hw/rtl/xcpp_if.sv -----
// Valid/ready channel interfaces for received bytes and decoded results.
interface xcpp_in_if;
  import xcpp_pkg::*;

  logic  valid;
  logic  ready;
  byte_t rx_byte;
  logic  frame_end;

  modport source (output valid, output rx_byte, output frame_end, input ready);
  modport sink (input valid, input rx_byte, input frame_end, output ready);
endinterface

interface xcpp_out_if;
  import xcpp_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command_word;
  logic [PLEN_W-1:0] payload_length;
  logic              invalid;
  byte_t             payload_byte;
  logic [LANE_W-1:0] payload_index;
  logic              last;

  modport source (output valid, output command_word, output payload_length,
                  output invalid, output payload_byte, output payload_index,
                  output last, input ready);
  modport sink (input valid, input command_word, input payload_length,
                input invalid, input payload_byte, input payload_index,
                input last, output ready);
endinterface

// ----- hw/rtl/xcpp_front.sv -----
// Byte collector: builds one frame, checks it and pushes a frame descriptor.
module xcpp_front import xcpp_pkg::*; #(
  parameter int FRAME_BYTES = 16,
  parameter int MAX_PAYLOAD = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  byte_t       cfg_wdata,
  xcpp_in_if.sink     in_if,
  input  xcpp_qstat_t qstat,
  output logic        push,
  output xcpp_frame_t push_data
);

  localparam int CNT_W = $clog2(FRAME_BYTES);

  byte_t              marker_r;
  logic [CNT_W-1:0]   cnt_r;
  byte_t              xor_r;
  logic               nz_r;
  byte_t              b0_r, b1_r, b2_r, b3_r;
  byte_t [PAY_LANES-1:0] payload_r;

  logic               fire;
  logic               done;
  byte_t              b;
  byte_t              cur_b0, cur_b1, cur_b2, cur_b3;
  byte_t              xor_all;
  logic               nz_all;
  logic               lane_hit;
  logic [LANE_W-1:0]  lane;
  byte_t [PAY_LANES-1:0] pay_cur;
  logic               len_bad;
  byte_t              len;

  assign in_if.ready = !qstat.full;
  assign fire        = in_if.valid && in_if.ready;
  assign b           = in_if.rx_byte;
  assign done        = fire && (in_if.frame_end || cnt_r == CNT_W'(FRAME_BYTES - 1));

  assign cur_b0 = (cnt_r == CNT_W'(0)) ? b : b0_r;
  assign cur_b1 = (cnt_r == CNT_W'(1)) ? b : b1_r;
  assign cur_b2 = (cnt_r == CNT_W'(2)) ? b : b2_r;
  assign cur_b3 = (cnt_r == CNT_W'(3)) ? b : b3_r;

  // Bytes past the checksum byte are zero, so the check reduces to the XOR of
  // everything received being zero, unless no nonzero byte sits at index two
  // or above.
  assign xor_all = xor_r ^ b;
  assign nz_all  = nz_r || (cnt_r >= CNT_W'(2) && b != '0);

  assign lane_hit = (32'(cnt_r) >= PAY_FIRST) && (32'(cnt_r) < PAY_FIRST + PAY_LANES);
  assign lane     = LANE_W'(32'(cnt_r) - PAY_FIRST);

  always_comb begin
    pay_cur = payload_r;
    if (lane_hit) begin
      pay_cur[lane] = b;
    end
  end

  assign len_bad = 32'(cur_b1) > MAX_PAYLOAD;
  assign len     = len_bad ? '0 : cur_b1;

  always_comb begin
    push_data.cmd_word = {cur_b2, cur_b3};
    push_data.plen     = len[PLEN_W-1:0];
    push_data.len_zero = (len == '0);
    push_data.bad      = (cur_b0 != marker_r) || len_bad || (nz_all && xor_all != '0);
    if (len == '0) begin
      push_data.last_pos = '0;
    end else if (32'(len) >= PAY_LANES) begin
      push_data.last_pos = LANE_W'(PAY_LANES - 1);
    end else begin
      push_data.last_pos = LANE_W'(len - 8'd1);
    end
    push_data.payload  = pay_cur;
  end

  assign push = done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marker_r <= START_MARKER_RST;
    end else if (cfg_we) begin
      marker_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || done) begin
      cnt_r     <= '0;
      xor_r     <= '0;
      nz_r      <= 1'b0;
      b0_r      <= '0;
      b1_r      <= '0;
      b2_r      <= '0;
      b3_r      <= '0;
      payload_r <= '0;
    end else if (fire) begin
      cnt_r     <= cnt_r + CNT_W'(1);
      xor_r     <= xor_all;
      nz_r      <= nz_all;
      b0_r      <= cur_b0;
      b1_r      <= cur_b1;
      b2_r      <= cur_b2;
      b3_r      <= cur_b3;
      payload_r <= pay_cur;
    end
  end

endmodule

// ----- hw/rtl/xcpp_queue.sv -----
// Two-entry queue of frame descriptors between the front end and the sequencer.
module xcpp_queue import xcpp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  xcpp_frame_t push_data,
  input  logic        pop,
  output xcpp_frame_t head,
  output xcpp_qstat_t qstat
);

  xcpp_frame_t entry_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  cnt_r;

  logic do_push;
  logic do_pop;

  assign qstat.full  = (cnt_r == 2'd2);
  assign qstat.empty = (cnt_r == 2'd0);
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign head        = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ----- hw/rtl/xcpp_back.sv -----
// Result sequencer: walks one descriptor and emits its results into an output register.
module xcpp_back import xcpp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  xcpp_frame_t head,
  input  xcpp_qstat_t qstat,
  output logic        pop,
  xcpp_out_if.source  out_if
);

  logic [LANE_W-1:0] pos_r;
  logic              valid_r;
  logic [CMD_W-1:0]  cmd_r;
  logic [PLEN_W-1:0] plen_r;
  logic              bad_r;
  byte_t             pbyte_r;
  logic [LANE_W-1:0] pidx_r;
  logic              last_r;

  logic load;
  logic at_last;

  // With a descriptor queued, the output register loads when empty or being drained.
  assign load    = !qstat.empty && (!valid_r || out_if.ready);
  assign at_last = (pos_r == head.last_pos);
  assign pop     = load && at_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pos_r   <= '0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        pos_r   <= at_last ? '0 : pos_r + LANE_W'(1);
      end else if (out_if.ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cmd_r   <= head.cmd_word;
      plen_r  <= head.plen;
      bad_r   <= head.bad;
      pbyte_r <= head.len_zero ? '0 : head.payload[pos_r];
      pidx_r  <= head.len_zero ? '0 : pos_r;
      last_r  <= at_last;
    end
  end

  assign out_if.valid          = valid_r;
  assign out_if.command_word   = cmd_r;
  assign out_if.payload_length = plen_r;
  assign out_if.invalid        = bad_r;
  assign out_if.payload_byte   = pbyte_r;
  assign out_if.payload_index  = pidx_r;
  assign out_if.last           = last_r;

endmodule

// ----- hw/rtl/xor_checked_command_packet_parser_top.sv -----
// Top level of the XOR-checked command packet parser.
//
//   Channel  Direction  Beat carries
//   in_if    sink       rx_byte, frame_end
//   out_if   source     command_word, payload_length, invalid, payload_byte,
//                       payload_index, last
//   cfg_*    write      start marker (8 bits)
//
// One byte is taken per cycle; the byte that ends a frame also pushes its descriptor.
// A frame yields max(1, min(len, 8)) results, one if len > MAX_PAYLOAD; one per cycle.
// The two-entry descriptor queue sets how far the front end runs ahead of the results.
// in_if stalls only while the queue holds two frames; out_if stalls hold the output beat.
// Reset is synchronous and clears all frame state; the start marker returns to 0xAA.
module xor_checked_command_packet_parser_top import xcpp_pkg::*; #(
  parameter int FRAME_BYTES = 16,
  parameter int MAX_PAYLOAD = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  byte_t      cfg_wdata,
  xcpp_in_if.sink    in_if,
  xcpp_out_if.source out_if
);

  xcpp_frame_t push_data;
  xcpp_frame_t head;
  xcpp_qstat_t qstat;
  logic        push;
  logic        pop;

  xcpp_front #(
    .FRAME_BYTES (FRAME_BYTES),
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_if     (in_if),
    .qstat     (qstat),
    .push      (push),
    .push_data (push_data)
  );

  xcpp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  xcpp_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .qstat  (qstat),
    .pop    (pop),
    .out_if (out_if)
  );

endmodule

// ----- hw/rtl/xcpp_checker.sv -----
// Port-level checks on the parser, attached to the top level by bind.
module xcpp_port_checks import xcpp_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CMD_W-1:0]  command_word,
  input logic [PLEN_W-1:0] payload_length,
  input logic              invalid,
  input byte_t             payload_byte,
  input logic [LANE_W-1:0] payload_index,
  input logic              last
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat shown right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(command_word) &&
      $stable(payload_length) && $stable(invalid) && $stable(payload_byte) &&
      $stable(payload_index) && $stable(last))
    else $error("stalled result beat changed");

  // Within a frame the next result follows the taken one without a gap.
  a_burst_next: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !last |=> out_valid &&
      payload_index == $past(payload_index) + 3'd1 &&
      command_word == $past(command_word) && invalid == $past(invalid))
    else $error("frame results not contiguous");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with no result pending");

endmodule

bind xor_checked_command_packet_parser_top xcpp_port_checks u_xcpp_port_checks (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_if.ready),
  .out_valid      (out_if.valid),
  .out_ready      (out_if.ready),
  .command_word   (out_if.command_word),
  .payload_length (out_if.payload_length),
  .invalid        (out_if.invalid),
  .payload_byte   (out_if.payload_byte),
  .payload_index  (out_if.payload_index),
  .last           (out_if.last)
);

// ----- verif/xcpp_checker.sv -----
// Scoreboard for the packet parser: predicts result beats from input beats and compares them.
module xcpp_checker import xcpp_pkg::*; #(
  parameter int FRAME_BYTES = 16,
  parameter int MAX_PAYLOAD = 8
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  cfg_we,
  input  byte_t cfg_wdata,
  xcpp_in_if    in_mon,
  xcpp_out_if   out_mon,
  output int    fail_count,
  output int    pending,
  output int    checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [PLEN_W-1:0] plen;
    logic              invalid;
    byte_t             data;
    logic [LANE_W-1:0] lane;
    logic              last;
  } result_t;

  byte_t   frame_buf [FRAME_BYTES];
  int      fill;
  byte_t   marker;
  result_t predicted_results [$];

  task automatic clear_frame();
    foreach (frame_buf[i]) frame_buf[i] = '0;
    fill = 0;
  endtask

  // Checks the buffered frame against the current start marker and queues its results.
  task automatic decode_frame();
    int      chk_pos;
    int      len;
    int      beats;
    bit      bad;
    byte_t   acc;
    result_t r;
    chk_pos = 0;
    for (int i = FRAME_BYTES - 1; i > 1; i--) begin
      if (chk_pos == 0 && frame_buf[i] != 8'h00) chk_pos = i;
    end
    bad = (frame_buf[0] != marker);
    len = int'(frame_buf[1]);
    if (len > MAX_PAYLOAD) begin
      bad = 1'b1;
      len = 0;
    end
    // With no nonzero byte past the length, the checksum byte is byte 0 itself.
    acc = frame_buf[0];
    for (int i = 1; i < chk_pos; i++) acc ^= frame_buf[i];
    if (acc != frame_buf[chk_pos]) bad = 1'b1;
    beats = (len == 0) ? 1 : len;
    if (beats > PAY_LANES) beats = PAY_LANES;
    for (int p = 0; p < beats; p++) begin
      r.cmd     = {frame_buf[2], frame_buf[3]};
      r.plen    = len[PLEN_W-1:0];
      r.invalid = bad;
      r.data    = (len == 0 || PAY_FIRST + p >= FRAME_BYTES) ? 8'h00 : frame_buf[PAY_FIRST + p];
      r.lane    = (len == 0) ? '0 : p[LANE_W-1:0];
      r.last    = (p == beats - 1);
      predicted_results.push_back(r);
    end
    clear_frame();
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst_n) begin
      clear_frame();
      marker = START_MARKER_RST;
      predicted_results.delete();
      fail_count = 0;
      checked = 0;
    end else begin
      if (cfg_we) marker = cfg_wdata;
      if (out_mon.valid && out_mon.ready) begin
        got = {out_mon.command_word, out_mon.payload_length, out_mon.invalid,
               out_mon.payload_byte, out_mon.payload_index, out_mon.last};
        if (predicted_results.size() == 0) begin
          $display("%0t: unexpected result beat cmd=%h len=%0d inv=%b byte=%h idx=%0d last=%b",
                   $time, got.cmd, got.plen, got.invalid, got.data, got.lane, got.last);
          fail_count++;
        end else begin
          want = predicted_results.pop_front();
          checked++;
          if (got.cmd !== want.cmd || got.plen !== want.plen || got.invalid !== want.invalid ||
              got.data !== want.data || got.lane !== want.lane || got.last !== want.last) begin
            $display("%0t: expected cmd=%h len=%0d inv=%b byte=%h idx=%0d last=%b", $time,
                     want.cmd, want.plen, want.invalid, want.data, want.lane, want.last);
            $display("%0t: actual   cmd=%h len=%0d inv=%b byte=%h idx=%0d last=%b", $time,
                     got.cmd, got.plen, got.invalid, got.data, got.lane, got.last);
            fail_count++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        frame_buf[fill] = in_mon.rx_byte;
        fill++;
        // The byte that fills the buffer ends the frame even without frame_end.
        if (in_mon.frame_end || fill == FRAME_BYTES) decode_frame();
      end
    end
    pending = predicted_results.size();
  end

endmodule

// ----- verif/tb_top.sv -----
// Testbench top for the packet parser: clock, reset, stimulus, stalls and the verdict.
module tb_top;
  import xcpp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_BYTES    = 16;
  localparam int MAX_PAYLOAD    = 8;
  localparam int PHASE_BYTES    = 46;
  localparam int WATCHDOG_LIMIT = 1000;

  logic  clk = 1'b0;
  logic  rst_n;
  logic  cfg_we;
  byte_t cfg_wdata;
  byte_t cur_marker;
  int    fail_count;
  int    pending;
  int    checked;
  int    bytes_sent;
  int    frames_sent;
  int    settings_used;
  int    quiet_cycles;
  int    in_run;
  int    out_run;

  xcpp_in_if  in_ch ();
  xcpp_out_if out_ch ();

  xor_checked_command_packet_parser_top #(
    .FRAME_BYTES(FRAME_BYTES),
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_if    (in_ch),
    .out_if   (out_ch)
  );

  xcpp_checker #(
    .FRAME_BYTES(FRAME_BYTES),
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_mon    (in_ch),
    .out_mon   (out_ch),
    .fail_count(fail_count),
    .pending   (pending),
    .checked   (checked)
  );

  always #5 clk = ~clk;

  // Gap before the next beat; now and then a run of back-to-back beats.
  function automatic int draw_gap(ref int run_left);
    if (run_left > 0) begin
      run_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      run_left = $urandom_range(5, 30);
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_byte(input byte_t b, input bit last_byte);
    int gap;
    gap = draw_gap(in_run);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.rx_byte   <= b;
    in_ch.frame_end <= last_byte;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    bytes_sent++;
    @(negedge clk);
  endtask

  // Bytes are packed first-byte-highest in the low n bytes of v.
  task automatic send_frame(input int n, input logic [8*FRAME_BYTES-1:0] v, input bit end_flag);
    for (int k = 0; k < n; k++) send_byte(v[8*(n-1-k) +: 8], (k == n - 1) ? end_flag : 1'b0);
    frames_sent++;
  endtask

  task automatic random_frame();
    logic [8*FRAME_BYTES-1:0] v;
    int    n;
    int    kind;
    int    len;
    byte_t acc;
    byte_t b;
    bit    end_flag;
    v = '0;
    n = 0;
    acc = '0;
    end_flag = 1'b1;
    kind = $urandom_range(0, 9);
    if (kind <= 7) begin
      // Well-formed frame, then possibly damaged by one flipped bit or a random length byte.
      len = $urandom_range(0, MAX_PAYLOAD);
      for (int k = 0; k < PAY_FIRST + len; k++) begin
        if (k == 0) b = cur_marker;
        else if (k == 1) b = byte_t'(len);
        else if ($urandom_range(0, 3) == 0) b = 8'h00;
        else b = byte_t'($urandom);
        acc ^= b;
        v = {v[8*FRAME_BYTES-9:0], b};
        n++;
      end
      v = {v[8*FRAME_BYTES-9:0], acc};
      n++;
      if (kind == 6) v[$urandom_range(0, 8*n - 1)] ^= 1'b1;
      if (kind == 7) v[8*(n-2) +: 8] = byte_t'($urandom);
    end else begin
      // Noise of random length, or a frame that runs until the buffer is full.
      n = (kind == 8) ? $urandom_range(1, FRAME_BYTES - 1) : FRAME_BYTES;
      if (kind == 9) end_flag = 1'($urandom);
      for (int k = 0; k < n; k++) begin
        b = (k == 0 && $urandom_range(0, 1) == 1) ? cur_marker : byte_t'($urandom);
        v = {v[8*FRAME_BYTES-9:0], b};
      end
    end
    send_frame(n, v, end_flag);
  endtask

  task automatic random_phase(input int budget);
    int target;
    target = bytes_sent + budget;
    while (bytes_sent < target) random_frame();
  endtask

  // The marker is only changed once every predicted result has come out.
  task automatic write_marker(input byte_t m);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_we     <= 1'b1;
    cfg_wdata  <= m;
    cur_marker = m;
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  initial begin
    int gap;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      gap = draw_gap(out_run);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no beat for %0d cycles, %0d results outstanding", $time, WATCHDOG_LIMIT,
               pending);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    byte_t plan [4];
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.rx_byte   = '0;
    in_ch.frame_end = 1'b0;
    bytes_sent      = 0;
    frames_sent     = 0;
    settings_used   = 1;
    in_run          = 0;
    out_run         = 0;
    cur_marker      = START_MARKER_RST;
    plan = '{8'h00, 8'hFF, byte_t'($urandom_range(1, 254)), START_MARKER_RST};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Lone start byte: length zero, checksum passes trivially.
    send_frame(1, 8'hAA, 1'b1);
    // Wrong start byte.
    send_frame(1, 8'h00, 1'b1);
    // Length above the maximum.
    send_frame(2, 16'hAA09, 1'b1);
    // Checksum byte does not match the XOR of the bytes before it.
    send_frame(6, 48'hAA01_0001_8055, 1'b1);
    // Full payload with extreme byte values and a correct checksum.
    send_frame(13, {8'hAA, 8'h08, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00,
                    8'hFF, 8'h00, 8'hFF, 8'h00, 8'hA2}, 1'b1);
    random_phase(PHASE_BYTES);
    foreach (plan[i]) begin
      write_marker(plan[i]);
      random_phase(PHASE_BYTES);
    end

    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    $display("Sent %0d bytes in %0d frames under %0d start-marker settings;", bytes_sent,
             frames_sent, settings_used);
    $display("compared %0d result beats with random stalls on both channels.", checked);
    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
